@@ src/ihex_pkg.sv @@
// Shared types, codes and character helpers for the Intel HEX record parser.
package ihex_pkg;

    // Parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CSUM  = 3'd5;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BADSUM    = 2'd1;
    localparam logic [1:0] ST_BADDIGIT  = 2'd2;
    localparam logic [1:0] ST_EARLYEND  = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    // Nibble count that completes a field: two for bytes, four (wraps to 0) for the address
    localparam logic [1:0] NIB_BYTE = 2'd2;
    localparam logic [1:0] NIB_WORD = 2'd0;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  record_type;
        logic [7:0]  byte_count;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    // Control characters other than CR/LF, and DEL and above, are dropped
    function automatic logic char_ignored(input logic [7:0] c);
        logic eol;
        eol = (c == CH_CR) || (c == CH_LF);
        return ((c < CH_SPACE) && !eol) || (c >= CH_DEL);
    endfunction

    // Decode one hex digit in either case
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.value  = 4'd0;
        if ((c >= CH_0) && (c <= CH_9)) begin
            d.is_hex = 1'b1;
            d.value  = c[3:0];
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - CH_UA) + HEX_TEN;
        end else if ((c >= CH_LA) && (c <= CH_LF_HEX)) begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - CH_LA) + HEX_TEN;
        end
        return d;
    endfunction

endpackage

@@ src/ihex_char_if.sv @@
// Character input channel: valid/ready handshake with one ASCII character.
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

@@ src/ihex_res_if.sv @@
// Result output channel: valid/ready handshake with one parser result.
interface ihex_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic [1:0]  status;

    modport source (output valid, output kind, output address, output data,
                    output record_type, output byte_count, output status,
                    input ready);
    modport sink   (input valid, input kind, input address, input data,
                    input record_type, input byte_count, input status,
                    output ready);
endinterface

@@ src/ihex_parser.sv @@
// Record parse state and the single-character update step.
module ihex_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_in,
    output logic              res_valid,
    output ihex_pkg::res_t    res
);

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  nibble_index_reg, nibble_index_next;
    logic [15:0] field_accum_reg, field_accum_next;
    logic [7:0]  count_field_reg, count_field_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] record_address_reg, record_address_next;
    logic [7:0]  byte_offset_reg, byte_offset_next;
    logic [7:0]  type_field_reg, type_field_next;
    logic [7:0]  running_sum_reg, running_sum_next;

    ihex_pkg::hex_digit_t digit;
    logic        eol;
    logic [15:0] accum_shift;
    logic [1:0]  nib_inc;
    logic [1:0]  nib_need;
    logic [7:0]  val_lo;
    logic [7:0]  sum_plus;

    assign digit       = ihex_pkg::hex_decode(char_in);
    assign eol         = (char_in == ihex_pkg::CH_CR) || (char_in == ihex_pkg::CH_LF);
    assign accum_shift = {field_accum_reg[11:0], digit.value};
    assign nib_inc     = nibble_index_reg + 2'd1;
    assign nib_need    = (phase_reg == ihex_pkg::PH_ADDR) ? ihex_pkg::NIB_WORD
                                                          : ihex_pkg::NIB_BYTE;
    assign val_lo      = accum_shift[7:0];
    assign sum_plus    = running_sum_reg + val_lo;

    // Compute next state and the result of the held character
    always_comb
    begin
        phase_next          = phase_reg;
        nibble_index_next   = nibble_index_reg;
        field_accum_next    = field_accum_reg;
        count_field_next    = count_field_reg;
        bytes_left_next     = bytes_left_reg;
        record_address_next = record_address_reg;
        byte_offset_next    = byte_offset_reg;
        type_field_next     = type_field_reg;
        running_sum_next    = running_sum_reg;
        res_valid           = 1'b0;
        res.kind            = ihex_pkg::KIND_STATUS;
        res.address         = record_address_reg;
        res.data            = 8'd0;
        res.record_type     = type_field_reg;
        res.byte_count      = count_field_reg;
        res.status          = ihex_pkg::ST_OK;

        if (!ihex_pkg::char_ignored(char_in)) begin
            unique case (phase_reg) inside
                ihex_pkg::PH_IDLE:
                begin
                    // Open a record on colon, clear all record fields
                    if (char_in == ihex_pkg::CH_COLON) begin
                        phase_next          = ihex_pkg::PH_COUNT;
                        nibble_index_next   = 2'd0;
                        field_accum_next    = 16'd0;
                        count_field_next    = 8'd0;
                        bytes_left_next     = 8'd0;
                        record_address_next = 16'd0;
                        byte_offset_next    = 8'd0;
                        type_field_next     = 8'd0;
                        running_sum_next    = 8'd0;
                    end
                end
                [ihex_pkg::PH_COUNT:ihex_pkg::PH_CSUM]:
                begin
                    if (eol || !digit.is_hex) begin
                        // Abort the record with an error status
                        res_valid         = 1'b1;
                        res.status        = eol ? ihex_pkg::ST_EARLYEND
                                                : ihex_pkg::ST_BADDIGIT;
                        phase_next        = ihex_pkg::PH_IDLE;
                        nibble_index_next = 2'd0;
                        field_accum_next  = 16'd0;
                    end else if (nib_inc != nib_need) begin
                        // Accumulate a partial field
                        field_accum_next  = accum_shift;
                        nibble_index_next = nib_inc;
                    end else begin
                        // Field complete
                        nibble_index_next = 2'd0;
                        field_accum_next  = 16'd0;
                        unique case (phase_reg)
                            ihex_pkg::PH_COUNT:
                            begin
                                count_field_next = val_lo;
                                bytes_left_next  = val_lo;
                                running_sum_next = sum_plus;
                                phase_next       = ihex_pkg::PH_ADDR;
                            end
                            ihex_pkg::PH_ADDR:
                            begin
                                record_address_next = accum_shift;
                                running_sum_next    = sum_plus + accum_shift[15:8];
                                phase_next          = ihex_pkg::PH_TYPE;
                            end
                            ihex_pkg::PH_TYPE:
                            begin
                                type_field_next  = val_lo;
                                running_sum_next = sum_plus;
                                phase_next       = (bytes_left_reg != 8'd0)
                                                   ? ihex_pkg::PH_DATA
                                                   : ihex_pkg::PH_CSUM;
                            end
                            ihex_pkg::PH_DATA:
                            begin
                                running_sum_next = sum_plus;
                                res_valid        = 1'b1;
                                res.kind         = ihex_pkg::KIND_DATA;
                                res.address      = record_address_reg
                                                   + {8'd0, byte_offset_reg};
                                res.data         = val_lo;
                                byte_offset_next = byte_offset_reg + 8'd1;
                                bytes_left_next  = bytes_left_reg - 8'd1;
                                if (bytes_left_reg == 8'd1) begin
                                    phase_next = ihex_pkg::PH_CSUM;
                                end
                            end
                            default:
                            begin
                                // Checksum: the full sum must wrap to zero
                                running_sum_next = sum_plus;
                                res_valid        = 1'b1;
                                res.status       = (sum_plus == 8'd0) ? ihex_pkg::ST_OK
                                                                      : ihex_pkg::ST_BADSUM;
                                phase_next       = ihex_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // Unused phase codes: return to the reset state
                    phase_next          = ihex_pkg::PH_IDLE;
                    nibble_index_next   = 2'd0;
                    field_accum_next    = 16'd0;
                    count_field_next    = 8'd0;
                    bytes_left_next     = 8'd0;
                    record_address_next = 16'd0;
                    byte_offset_next    = 8'd0;
                    type_field_next     = 8'd0;
                    running_sum_next    = 8'd0;
                end
            endcase
        end
    end

    // Advance the parse state on each processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg          <= ihex_pkg::PH_IDLE;
            nibble_index_reg   <= 2'd0;
            field_accum_reg    <= 16'd0;
            count_field_reg    <= 8'd0;
            bytes_left_reg     <= 8'd0;
            record_address_reg <= 16'd0;
            byte_offset_reg    <= 8'd0;
            type_field_reg     <= 8'd0;
            running_sum_reg    <= 8'd0;
        end else if (step) begin
            phase_reg          <= phase_next;
            nibble_index_reg   <= nibble_index_next;
            field_accum_reg    <= field_accum_next;
            count_field_reg    <= count_field_next;
            bytes_left_reg     <= bytes_left_next;
            record_address_reg <= record_address_next;
            byte_offset_reg    <= byte_offset_next;
            type_field_reg     <= type_field_next;
            running_sum_reg    <= running_sum_next;
        end
    end

    // A data byte comes only out of the data phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == ihex_pkg::KIND_DATA) |-> phase_reg == ihex_pkg::PH_DATA)
        else $error("data result outside data phase");

    // Every status result closes the record
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.kind == ihex_pkg::KIND_STATUS)
        |=> phase_reg == ihex_pkg::PH_IDLE)
        else $error("record not closed after status");

    // Only the address field runs past two nibbles
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != ihex_pkg::PH_ADDR) |-> !nibble_index_reg[1])
        else $error("nibble index out of range for byte field");

    // Idle holds no partial field
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ihex_pkg::PH_IDLE) |-> (nibble_index_reg == 2'd0
                                              && field_accum_reg == 16'd0))
        else $error("partial field left in idle");

    // The data phase always has bytes outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ihex_pkg::PH_DATA) |-> bytes_left_reg != 8'd0)
        else $error("data phase with no bytes left");

endmodule

@@ src/ihex_out_reg.sv @@
// Output result register driving the result channel.
module ihex_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load_valid,
    input  ihex_pkg::res_t  load_res,
    output logic            free,
    ihex_res_if.source      results
);

    logic           valid_reg;
    ihex_pkg::res_t res_reg;

    // Register is free when empty or being drained this cycle
    assign free = !valid_reg || results.ready;

    // Load a new result or drop the delivered one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load_valid;
        end
    end

    // Hold the payload until transfer
    always_ff @(posedge clk)
    begin
        if (free && load_valid) begin
            res_reg <= load_res;
        end
    end

    assign results.valid       = valid_reg;
    assign results.kind        = res_reg.kind;
    assign results.address     = res_reg.address;
    assign results.data        = res_reg.data;
    assign results.record_type = res_reg.record_type;
    assign results.byte_count  = res_reg.byte_count;
    assign results.status      = res_reg.status;

endmodule

@@ src/intel_hex_record_parser_unit.sv @@
// Top level: Intel HEX record parser, input register, parse step, result register.
// Each character is held in the input register, its result in the result register.
// Throughput: one character per cycle; the input register and the result
// register stall only while a finished result waits on the result channel.
// Reset: rst_n clears all parse state to idle (waiting for a colon) and
// empties both registers; payload registers are not reset.
module intel_hex_record_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    ihex_char_if.sink   chars,
    ihex_res_if.source  results
);

    logic           in_valid_reg;
    logic [7:0]     in_char_reg;
    logic           advance;
    logic           out_free;
    logic           res_valid;
    ihex_pkg::res_t res;

    // The held character moves on unless its result cannot be stored
    assign advance     = in_valid_reg && (!res_valid || out_free);
    assign chars.ready = !in_valid_reg || advance;

    // Capture characters on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (chars.ready) begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid) begin
            in_char_reg <= chars.char_in;
        end
    end

    ihex_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_in   (in_char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ihex_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (advance && res_valid),
        .load_res   (res),
        .free       (out_free),
        .results    (results)
    );

endmodule
